>>> src/twhs_pkg.sv
// ------------------------------------------------------------------------------------------
// twhs_pkg
// Shared types, codes and constants of the two-wire humidity sensor master.
// ------------------------------------------------------------------------------------------
package twhs_pkg;

   localparam int OP_W       = 2;
   localparam int HALF_W     = 16;
   localparam int GAP_W      = 20;
   localparam int OFFS_W     = 16;
   localparam int TICK_W     = 20;
   localparam int BIT_W      = 4;
   localparam int CMD_W      = 8;
   localparam int READ_W     = 16;
   localparam int RAW_W      = 14;
   localparam int SCALED_W   = 12;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 20;

   localparam int QUEUE_DEPTH = 4;

   // request codes
   localparam logic [OP_W-1:0] OP_TICK = 2'd0;
   localparam logic [OP_W-1:0] OP_TEMP = 2'd1;
   localparam logic [OP_W-1:0] OP_HUM  = 2'd2;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_HALF_PERIOD = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_START_GAP   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_TEMP_OFFSET = 2'd2;

   localparam logic [HALF_W-1:0]        HALF_RESET = 16'd50;
   localparam logic [GAP_W-1:0]         GAP_RESET  = 20'd5000;
   localparam logic signed [OFFS_W-1:0] OFFS_RESET = -16'sd3965;

   localparam logic [CMD_W-1:0] CMD_TEMP = 8'h03;
   localparam logic [CMD_W-1:0] CMD_HUM  = 8'h05;

   // start pattern, bit i is half period i
   localparam logic [5:0] START_SCK = 6'b110110;
   localparam logic [5:0] START_SDA = 6'b100011;
   localparam logic [2:0] START_LAST = 3'd5;

   // humidity polynomial in Q24, already scaled by ten
   localparam logic signed [36:0] HUM_K1     = -37'sd343396057;
   localparam logic [22:0]        HUM_K2     = 23'd6157238;
   localparam logic [8:0]         HUM_K3_MAG = 9'd268;

   // x / 10 for 16-bit x as (x * recip) >> 19
   localparam logic [15:0] DIV10_RECIP = 16'd52429;

   typedef enum logic [3:0] {
      PH_IDLE,
      PH_START,
      PH_GAP,
      PH_CMD,
      PH_WAIT,
      PH_READ1,
      PH_READ2
   } phase_type;

   typedef struct packed {
      logic             sck;
      logic             sda_out;
      logic             sda_oe;
      logic             busy;
      logic             done;
      logic             kind;
      logic [RAW_W-1:0] raw;
   } tick_rec_type;

   typedef struct packed {
      logic [HALF_W-1:0]        half_period;
      logic [GAP_W-1:0]         start_gap;
      logic signed [OFFS_W-1:0] temp_offset;
   } cfg_type;

endpackage

>>> src/twhs_if.sv
// ------------------------------------------------------------------------------------------
// twhs_if
// Valid/ready channels of the sensor master: tick requests, results, register writes.
// ------------------------------------------------------------------------------------------
interface twhs_req_if import twhs_pkg::*; ();
   logic            valid;
   logic            ready;
   logic [OP_W-1:0] op;
   logic            sda_in;

   modport source (output valid, output op, output sda_in, input ready);
   modport sink   (input valid, input op, input sda_in, output ready);
endinterface

interface twhs_rsp_if import twhs_pkg::*; ();
   logic                       valid;
   logic                       ready;
   logic                       sck;
   logic                       sda_out;
   logic                       sda_oe;
   logic                       busy_res;
   logic                       done_res;
   logic                       kind;
   logic [RAW_W-1:0]           raw_reading;
   logic signed [SCALED_W-1:0] scaled_value;

   modport source (output valid, output sck, output sda_out, output sda_oe, output busy_res,
                   output done_res, output kind, output raw_reading, output scaled_value,
                   input ready);
   modport sink   (input valid, input sck, input sda_out, input sda_oe, input busy_res,
                   input done_res, input kind, input raw_reading, input scaled_value,
                   output ready);
endinterface

interface twhs_csr_if import twhs_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

>>> src/twhs_front.sv
// ------------------------------------------------------------------------------------------
// twhs_front
// Pin sequencer: takes one tick word, drives the pin levels and pushes a tick record.
// ------------------------------------------------------------------------------------------
module twhs_front import twhs_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   twhs_req_if.sink     req_ch,
   input  cfg_type      cfg,
   input  logic         q_full,
   output logic         push,
   output tick_rec_type rec
);

   phase_type          phase_ff, phase_in;
   logic [TICK_W-1:0]  tick_ff, tick_in;
   logic [BIT_W-1:0]   bit_ff, bit_in;
   logic [CMD_W-1:0]   cmd_ff, cmd_in;
   logic [READ_W-1:0]  read_ff, read_in;
   logic               last_sda_ff, last_sda_in;
   logic               kind_ff, kind_in;
   logic               clk_lvl_ff, clk_lvl_in;

   logic               fire;
   logic [TICK_W-1:0]  step_len;
   logic [TICK_W-1:0]  len_eff;
   logic [TICK_W-1:0]  tick_inc;
   logic               step_end;
   logic [TICK_W-1:0]  tick_step;
   logic [2:0]         start_idx;

   assign req_ch.ready = !q_full;
   assign fire         = req_ch.valid && !q_full;
   assign push         = fire;

   // step timer: a zero length counts as one tick
   assign step_len  = (phase_ff == PH_GAP) ? cfg.start_gap
                                           : {{(TICK_W-HALF_W){1'b0}}, cfg.half_period};
   assign len_eff   = (step_len == '0) ? TICK_W'(1) : step_len;
   assign tick_inc  = tick_ff + TICK_W'(1);
   assign step_end  = (tick_inc >= len_eff);
   assign tick_step = step_end ? '0 : tick_inc;
   assign start_idx = (bit_ff > BIT_W'(START_LAST)) ? START_LAST : bit_ff[2:0];

   always_comb begin
      phase_in    = phase_ff;
      tick_in     = tick_ff;
      bit_in      = bit_ff;
      cmd_in      = cmd_ff;
      read_in     = read_ff;
      kind_in     = kind_ff;
      clk_lvl_in  = clk_lvl_ff;
      last_sda_in = req_ch.sda_in;
      rec         = '0;
      rec.busy    = (phase_ff != PH_IDLE);

      case (phase_ff)
         PH_IDLE: begin
            if (req_ch.op == OP_TEMP || req_ch.op == OP_HUM) begin
               kind_in    = (req_ch.op == OP_HUM);
               cmd_in     = (req_ch.op == OP_HUM) ? CMD_HUM : CMD_TEMP;
               phase_in   = PH_START;
               bit_in     = '0;
               tick_in    = '0;
               clk_lvl_in = 1'b0;
            end
         end
         PH_START: begin
            rec.sck     = START_SCK[start_idx];
            rec.sda_out = START_SDA[start_idx];
            rec.sda_oe  = 1'b1;
            tick_in     = tick_step;
            if (step_end) begin
               if (start_idx == START_LAST) begin
                  phase_in = PH_GAP;
                  bit_in   = '0;
               end else begin
                  bit_in = {1'b0, start_idx} + BIT_W'(1);
               end
            end
         end
         PH_GAP: begin
            rec.sda_out = 1'b1;
            rec.sda_oe  = 1'b1;
            tick_in     = tick_step;
            if (step_end) begin
               phase_in   = PH_CMD;
               bit_in     = '0;
               clk_lvl_in = 1'b0;
            end
         end
         PH_CMD: begin
            rec.sck = clk_lvl_ff;
            if (bit_ff < BIT_W'(8)) begin
               rec.sda_oe  = 1'b1;
               rec.sda_out = cmd_ff[CMD_W-1];
            end
            tick_in = tick_step;
            if (step_end) begin
               if (!clk_lvl_ff) begin
                  clk_lvl_in = 1'b1;
               end else begin
                  clk_lvl_in = 1'b0;
                  if (bit_ff < BIT_W'(8)) begin
                     cmd_in = {cmd_ff[CMD_W-2:0], 1'b0};
                     bit_in = bit_ff + BIT_W'(1);
                  end else begin
                     phase_in = PH_WAIT;
                     bit_in   = '0;
                  end
               end
            end
         end
         PH_WAIT: begin
            if (last_sda_ff && !req_ch.sda_in) begin
               phase_in   = PH_READ1;
               bit_in     = '0;
               clk_lvl_in = 1'b0;
               tick_in    = '0;
               read_in    = '0;
            end
         end
         PH_READ1, PH_READ2: begin
            rec.sck = clk_lvl_ff;
            if (bit_ff >= BIT_W'(8)) begin
               rec.sda_oe  = 1'b1;
               rec.sda_out = (phase_ff == PH_READ2);
            end
            tick_in = tick_step;
            if (step_end) begin
               if (!clk_lvl_ff) begin
                  if (bit_ff < BIT_W'(8)) begin
                     read_in = {read_ff[READ_W-2:0], req_ch.sda_in};
                  end
                  clk_lvl_in = 1'b1;
               end else begin
                  clk_lvl_in = 1'b0;
                  if (bit_ff < BIT_W'(8)) begin
                     bit_in = bit_ff + BIT_W'(1);
                  end else if (phase_ff == PH_READ1) begin
                     phase_in = PH_READ2;
                     bit_in   = '0;
                  end else begin
                     rec.done = 1'b1;
                     rec.kind = kind_ff;
                     rec.raw  = kind_ff ? {2'b00, read_ff[11:0]} : read_ff[RAW_W-1:0];
                     phase_in = PH_IDLE;
                     bit_in   = '0;
                     tick_in  = '0;
                  end
               end
            end
         end
         default: begin
            phase_in = PH_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PH_IDLE;
         tick_ff     <= '0;
         bit_ff      <= '0;
         cmd_ff      <= '0;
         read_ff     <= '0;
         last_sda_ff <= 1'b1;
         kind_ff     <= 1'b0;
         clk_lvl_ff  <= 1'b0;
      end else if (fire) begin
         phase_ff    <= phase_in;
         tick_ff     <= tick_in;
         bit_ff      <= bit_in;
         cmd_ff      <= cmd_in;
         read_ff     <= read_in;
         last_sda_ff <= last_sda_in;
         kind_ff     <= kind_in;
         clk_lvl_ff  <= clk_lvl_in;
      end
   end

   // a completion only ever comes out of a transaction in flight
   a_done_busy: assert property (@(posedge clock) disable iff (reset)
      push && rec.done |-> rec.busy && (phase_ff == PH_READ2))
      else $error("completion outside second read byte");

   // hold the sequencer while no tick is taken
   a_hold_idle: assert property (@(posedge clock) disable iff (reset)
      !fire |=> $stable(phase_ff) && $stable(tick_ff))
      else $error("sequencer moved without a tick");

endmodule

>>> src/twhs_queue.sv
// ------------------------------------------------------------------------------------------
// twhs_queue
// Short FIFO of tick records between the pin sequencer and the result pipeline.
// ------------------------------------------------------------------------------------------
module twhs_queue import twhs_pkg::*; #(
   parameter int Depth = QUEUE_DEPTH
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         push,
   input  tick_rec_type wr_rec,
   input  logic         pop,
   output logic         full,
   output logic         not_empty,
   output tick_rec_type rd_rec
);

   localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int CntW = $clog2(Depth + 1);

   tick_rec_type    store_ff [Depth];
   logic [PtrW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0] count_ff, count_in;

   assign full      = (count_ff == CntW'(Depth));
   assign not_empty = (count_ff != '0);
   assign rd_rec    = store_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PtrW'(Depth - 1)) ? '0 : wr_ptr_ff + PtrW'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrW'(Depth - 1)) ? '0 : rd_ptr_ff + PtrW'(1);
      end
      case ({push, pop})
         2'b10:   count_in = count_ff + CntW'(1);
         2'b01:   count_in = count_ff - CntW'(1);
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         store_ff[wr_ptr_ff] <= wr_rec;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CntW'(Depth))
      else $error("queue fill beyond depth");

   a_push_grows: assert property (@(posedge clock) disable iff (reset)
      push && !pop |=> count_ff == $past(count_ff) + CntW'(1))
      else $error("queue fill did not advance on push");

endmodule

>>> src/twhs_back.sv
// ------------------------------------------------------------------------------------------
// twhs_back
// Result pipeline: scales a finished reading over two stages and holds the result word.
// ------------------------------------------------------------------------------------------
module twhs_back import twhs_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  logic signed [OFFS_W-1:0] temp_offset,
   input  logic                     q_valid,
   input  tick_rec_type             q_rec,
   output logic                     pop,
   twhs_rsp_if.source               rsp_ch
);

   logic                advance;

   // stage 1
   logic signed [16:0]  tsum;
   logic [16:0]         tmag;
   logic [11:0]         hx;
   logic                v1_ff;
   tick_rec_type        rec1_ff;
   logic                tneg1_ff;
   logic [15:0]         tabs1_ff;
   logic [23:0]         xx1_ff;
   logic [34:0]         k2x1_ff;

   // stage 2
   logic [31:0]         tprod;
   logic                v2_ff;
   tick_rec_type        rec2_ff;
   logic                tneg2_ff;
   logic [12:0]         tq2_ff;
   logic [34:0]         k2x2_ff;
   logic [32:0]         k3xx2_ff;

   // result word
   logic signed [13:0]  tval;
   logic signed [SCALED_W-1:0] tsat;
   logic signed [36:0]  hacc;
   logic [11:0]         hq;
   logic signed [SCALED_W-1:0] hsat;
   logic signed [SCALED_W-1:0] scaled_in;
   logic                out_valid_ff;
   tick_rec_type        out_rec_ff;
   logic signed [SCALED_W-1:0] out_scaled_ff;

   // advance the whole pipe unless the result word is stuck
   assign advance = !out_valid_ff || rsp_ch.ready;
   assign pop     = advance && q_valid;

   assign tsum = $signed({3'b000, q_rec.raw}) + $signed({temp_offset[OFFS_W-1], temp_offset});
   assign tmag = tsum[16] ? (17'd0 - tsum) : tsum;
   assign hx   = q_rec.raw[11:0];

   // divide the magnitude by ten through the reciprocal
   assign tprod = 32'(tabs1_ff) * 32'(DIV10_RECIP);

   assign tval = tneg2_ff ? -$signed({1'b0, tq2_ff}) : $signed({1'b0, tq2_ff});
   always_comb begin
      if (tval > 14'sd2047) begin
         tsat = 12'sd2047;
      end else if (tval < -14'sd2048) begin
         tsat = -12'sd2048;
      end else begin
         tsat = tval[SCALED_W-1:0];
      end
   end

   // negative sums clamp to zero, so a plain shift gives the truncated quotient
   assign hacc = HUM_K1 + $signed({2'b00, k2x2_ff}) - $signed({4'b0000, k3xx2_ff});
   assign hq   = hacc[35:24];
   always_comb begin
      if (hacc[36]) begin
         hsat = '0;
      end else if (hacc[35] || hq[11]) begin
         hsat = 12'sd2047;
      end else begin
         hsat = $signed(hq);
      end
   end

   always_comb begin
      if (!rec2_ff.done) begin
         scaled_in = '0;
      end else if (rec2_ff.kind) begin
         scaled_in = hsat;
      end else begin
         scaled_in = tsat;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         v1_ff        <= q_valid;
         v2_ff        <= v1_ff;
         out_valid_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rec1_ff       <= q_rec;
         tneg1_ff      <= tsum[16];
         tabs1_ff      <= tmag[15:0];
         xx1_ff        <= 24'(hx) * 24'(hx);
         k2x1_ff       <= 35'(HUM_K2) * 35'(hx);
         rec2_ff       <= rec1_ff;
         tneg2_ff      <= tneg1_ff;
         tq2_ff        <= tprod[31:19];
         k2x2_ff       <= k2x1_ff;
         k3xx2_ff      <= 33'(xx1_ff) * 33'(HUM_K3_MAG);
         out_rec_ff    <= rec2_ff;
         out_scaled_ff <= scaled_in;
      end
   end

   assign rsp_ch.valid        = out_valid_ff;
   assign rsp_ch.sck          = out_rec_ff.sck;
   assign rsp_ch.sda_out      = out_rec_ff.sda_out;
   assign rsp_ch.sda_oe       = out_rec_ff.sda_oe;
   assign rsp_ch.busy_res     = out_rec_ff.busy;
   assign rsp_ch.done_res     = out_rec_ff.done;
   assign rsp_ch.kind         = out_rec_ff.kind;
   assign rsp_ch.raw_reading  = out_rec_ff.raw;
   assign rsp_ch.scaled_value = out_scaled_ff;

   a_idle_zero: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && !out_rec_ff.done |-> out_scaled_ff == '0)
      else $error("scaled value on a tick without completion");

   a_hum_positive: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && out_rec_ff.done && out_rec_ff.kind |-> !out_scaled_ff[SCALED_W-1])
      else $error("negative humidity word");

endmodule

>>> src/two_wire_humidity_sensor_master_top.sv
// ------------------------------------------------------------------------------------------
// two_wire_humidity_sensor_master_top
// Two-wire humidity/temperature sensor master: pin sequencer, queue and result pipeline.
// ------------------------------------------------------------------------------------------
// Path: a tick word taken goes to the queue, the two scaling stages, then the result word.
// Throughput: one tick word per cycle while the queue has room; the pin sequencer finishes
// a tick in the cycle it takes it; the result side: two scaling stages and the output word.
// Reset: synchronous, active high; registers return to their reset values, the sequencer
// goes idle and the queue and pipeline empty. No clearing pass.
// ------------------------------------------------------------------------------------------
module two_wire_humidity_sensor_master_top import twhs_pkg::*; #(
   parameter int QueueDepth = QUEUE_DEPTH
) (
   input  logic       clock,
   input  logic       reset,
   twhs_req_if.sink   req_ch,
   twhs_rsp_if.source rsp_ch,
   twhs_csr_if.sink   csr_ch
);

   cfg_type      cfg_ff, cfg_in;
   logic         q_full;
   logic         q_push;
   logic         q_pop;
   logic         q_valid;
   tick_rec_type front_rec;
   tick_rec_type q_rec;

   // register port: always ready, writes to an unknown index are dropped
   assign csr_ch.ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_ch.valid) begin
         case (csr_ch.index)
            CSR_HALF_PERIOD: cfg_in.half_period = csr_ch.data[HALF_W-1:0];
            CSR_START_GAP:   cfg_in.start_gap   = csr_ch.data[GAP_W-1:0];
            CSR_TEMP_OFFSET: cfg_in.temp_offset = $signed(csr_ch.data[OFFS_W-1:0]);
            default:         cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.half_period <= HALF_RESET;
         cfg_ff.start_gap   <= GAP_RESET;
         cfg_ff.temp_offset <= OFFS_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // front: one tick word in, pin levels and completion flags out as a record
   twhs_front u_front (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .cfg    (cfg_ff),
      .q_full (q_full),
      .push   (q_push),
      .rec    (front_rec)
   );

   // queue: lets the sequencer carry on while the result side is stalled
   twhs_queue #(
      .Depth (QueueDepth)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .wr_rec    (front_rec),
      .pop       (q_pop),
      .full      (q_full),
      .not_empty (q_valid),
      .rd_rec    (q_rec)
   );

   // back: temperature and humidity scaling, then the result word
   twhs_back u_back (
      .clock       (clock),
      .reset       (reset),
      .temp_offset (cfg_ff.temp_offset),
      .q_valid     (q_valid),
      .q_rec       (q_rec),
      .pop         (q_pop),
      .rsp_ch      (rsp_ch)
   );

endmodule
